### rtl/rtsp_pkg.sv
package rtsp_pkg;

    localparam int MAX_NODES   = 256;
    localparam int NODE_W      = 8;
    localparam int CNT_W       = 9;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;
    localparam int TOTAL_W     = DIST_BITS + 1;
    localparam int ADJ_AW      = 2 * NODE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = DIST_INF - 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_NODE   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_WR,
        OP_LOAD,
        OP_INIT,
        OP_SCAN,
        OP_MARK,
        OP_RELAX,
        OP_READT,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic round_inc;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cnt_last;
        logic no_rounds;
        logic round_last;
        logic ends_bad;
        logic best_inf;
        logic pass;
    } t_sts;

endpackage

### rtl/rtsp_ctrl.sv
module rtsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  rtsp_pkg::t_sts i_sts,
    output rtsp_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import rtsp_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_LOAD  = 12'b000000000100,
        S_INIT  = 12'b000000001000,
        S_SCAN  = 12'b000000010000,
        S_SDRN  = 12'b000000100000,
        S_MARK  = 12'b000001000000,
        S_RELAX = 12'b000010000000,
        S_RDRN  = 12'b000100000000,
        S_READT = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = OP_NONE;
        o_cmd.round_inc = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start && !i_func) o_cmd.op = OP_WR;
                if (i_start && i_func) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = i_sts.ends_bad ? S_DONE : S_INIT;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (i_sts.cnt_last) n_state = i_sts.no_rounds ? S_READT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.cnt_last) n_state = S_SDRN;
            end
            S_SDRN: begin
                n_state = S_MARK;
            end
            S_MARK: begin
                o_cmd.op = OP_MARK;
                if (i_sts.best_inf) begin
                    o_cmd.round_inc = 1'b1;
                    n_state = i_sts.round_last ? S_READT : S_SCAN;
                end else begin
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                o_cmd.op = OP_RELAX;
                if (i_sts.cnt_last) n_state = S_RDRN;
            end
            S_RDRN: begin
                o_cmd.round_inc = 1'b1;
                n_state = i_sts.round_last ? S_READT : S_SCAN;
            end
            S_READT: begin
                o_cmd.op = OP_READT;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = i_sts.pass ? S_DONE : S_INIT;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

### rtl/rtsp_dp.sv
module rtsp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rtsp_pkg::t_cmd                      i_cmd,
    output rtsp_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [rtsp_pkg::NODE_W-1:0]         i_from_node,
    input  logic [rtsp_pkg::NODE_W-1:0]         i_to_node,
    input  logic [rtsp_pkg::WEIGHT_BITS-1:0]    i_edge_weight,
    output logic [rtsp_pkg::DIST_BITS-1:0]      o_forward_distance,
    output logic [rtsp_pkg::DIST_BITS-1:0]      o_backward_distance,
    output logic [rtsp_pkg::TOTAL_W-1:0]        o_total_distance,
    output logic                                o_unreachable
);
    import rtsp_pkg::*;

    logic [WEIGHT_BITS-1:0] adj_mem [2**ADJ_AW];
    logic [DIST_BITS:0]     dist_mem [MAX_NODES];

    logic [CNT_W-1:0]       r_cfg_n;
    logic [NODE_W-1:0]      r_cfg_src, r_cfg_dst;
    logic [CNT_W-1:0]       r_n, r_cnt, r_round;
    logic [NODE_W-1:0]      r_start, r_tgt, r_pick, r_v_d;
    logic                   r_pass;
    logic [ADJ_AW-1:0]      r_clr_addr;
    logic [DIST_BITS-1:0]   r_best, r_du, r_fwd, r_bwd;
    logic [WEIGHT_BITS-1:0] r_adj_q;
    logic [DIST_BITS:0]     r_dist_q;
    t_op                    r_p_op;

    logic [CNT_W-1:0]       n_eff;
    logic                   ends_bad;
    logic                   d_we;
    logic [NODE_W-1:0]      d_waddr, d_raddr;
    logic [DIST_BITS:0]     d_wdata;
    logic [TOTAL_W-1:0]     cand;
    logic [DIST_BITS-1:0]   cand_sat;
    logic                   relax_wr;
    logic                   cnt_step;

    always_comb begin
        if (r_cfg_n == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_cfg_n > CNT_W'(MAX_NODES)) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = r_cfg_n;
        end
    end

    assign ends_bad = ({1'b0, r_cfg_src} >= n_eff) || ({1'b0, r_cfg_dst} >= n_eff);

    assign o_sts.clr_last   = (r_clr_addr == {ADJ_AW{1'b1}});
    assign o_sts.cnt_last   = (r_cnt == r_n - CNT_W'(1));
    assign o_sts.no_rounds  = (r_n == CNT_W'(1));
    assign o_sts.round_last = (r_round + CNT_W'(2) == r_n);
    assign o_sts.ends_bad   = ends_bad;
    assign o_sts.best_inf   = (r_best == DIST_INF);
    assign o_sts.pass       = r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n   <= CNT_W'(1);
            r_cfg_src <= '0;
            r_cfg_dst <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NODE_COUNT:  r_cfg_n   <= i_cfg_data;
                REG_SOURCE_NODE: r_cfg_src <= i_cfg_data[NODE_W-1:0];
                REG_DEST_NODE:   r_cfg_dst <= i_cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // adjacency store with clearing sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLR) begin
            adj_mem[r_clr_addr] <= '0;
        end else if (i_cmd.op == OP_WR) begin
            adj_mem[{i_from_node, i_to_node}] <= i_edge_weight;
        end
        r_adj_q <= adj_mem[{r_pick, r_cnt[NODE_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.op == OP_CLR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // relaxation of the entry read in the previous cycle
    assign cand     = {1'b0, r_du} + TOTAL_W'(r_adj_q);
    assign cand_sat = (cand > TOTAL_W'(DIST_MAX)) ? DIST_MAX : cand[DIST_BITS-1:0];
    assign relax_wr = (r_p_op == OP_RELAX) && !r_dist_q[DIST_BITS] &&
                      (r_adj_q != '0) && (cand_sat < r_dist_q[DIST_BITS-1:0]);

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_cnt[NODE_W-1:0];
        d_wdata = '0;
        if (i_cmd.op == OP_INIT) begin
            d_we    = 1'b1;
            d_wdata = {1'b0, (r_cnt[NODE_W-1:0] == r_start) ? '0 : DIST_INF};
        end else if (i_cmd.op == OP_MARK) begin
            d_we    = 1'b1;
            d_waddr = r_pick;
            d_wdata = {1'b1, r_best};
        end else if (relax_wr) begin
            d_we    = 1'b1;
            d_waddr = r_v_d;
            d_wdata = {1'b0, cand_sat};
        end
        d_raddr = (i_cmd.op == OP_READT) ? r_tgt : r_cnt[NODE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) dist_mem[d_waddr] <= d_wdata;
        r_dist_q <= dist_mem[d_raddr];
    end

    assign cnt_step = (i_cmd.op == OP_INIT) || (i_cmd.op == OP_SCAN) ||
                      (i_cmd.op == OP_RELAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_round <= '0;
            r_p_op  <= OP_NONE;
            r_pass  <= 1'b0;
        end else begin
            r_p_op <= i_cmd.op;
            if (cnt_step && !o_sts.cnt_last) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (i_cmd.op == OP_INIT) begin
                r_round <= '0;
            end else if (i_cmd.round_inc) begin
                r_round <= r_round + 1'b1;
            end
            if (i_cmd.op == OP_LOAD) begin
                r_pass <= 1'b0;
            end else if (i_cmd.op == OP_FIN) begin
                r_pass <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v_d <= r_cnt[NODE_W-1:0];
        if (i_cmd.op == OP_LOAD) begin
            r_n     <= n_eff;
            r_start <= r_cfg_src;
            r_tgt   <= r_cfg_dst;
            if (ends_bad) begin
                r_fwd <= DIST_INF;
                r_bwd <= DIST_INF;
            end
        end
        if (i_cmd.op == OP_SCAN && r_cnt == '0) begin
            r_best <= DIST_INF;
            r_pick <= '0;
        end else if (r_p_op == OP_SCAN && !r_dist_q[DIST_BITS] &&
                     r_dist_q[DIST_BITS-1:0] <= r_best) begin
            r_best <= r_dist_q[DIST_BITS-1:0];
            r_pick <= r_v_d;
        end
        if (i_cmd.op == OP_MARK) r_du <= r_best;
        if (i_cmd.op == OP_FIN) begin
            if (r_pass) begin
                r_bwd <= r_dist_q[DIST_BITS-1:0];
            end else begin
                r_fwd   <= r_dist_q[DIST_BITS-1:0];
                r_start <= r_tgt;
                r_tgt   <= r_start;
            end
        end
    end

    assign o_forward_distance  = r_fwd;
    assign o_backward_distance = r_bwd;
    assign o_unreachable       = (r_fwd == DIST_INF) || (r_bwd == DIST_INF);
    assign o_total_distance    = o_unreachable ? {TOTAL_W{1'b1}} :
                                 ({1'b0, r_fwd} + {1'b0, r_bwd});

endmodule

### rtl/round_trip_shortest_path_top.sv
// channel    | ports                                            | handshake
// -----------+--------------------------------------------------+----------------------------
// command    | i_func i_from_node i_to_node i_edge_weight       | i_start high, o_busy low
// result     | o_forward/backward/total_distance o_unreachable  | o_done strobe, one cycle
// config     | i_cfg_idx i_cfg_data                             | i_cfg_we, no wait
//
// an edge write streams at one per cycle while o_busy is low
// a run makes two passes of n-1 rounds, each round a scan of the distance memory then, unless
// no node left is reachable, a walk of one adjacency row, one node per cycle
// after reset a sweep clears the whole adjacency memory, o_busy high
// the receiver cannot stall: o_done is high for exactly one cycle
module round_trip_shortest_path_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_func,
    input  logic [rtsp_pkg::NODE_W-1:0]         i_from_node,
    input  logic [rtsp_pkg::NODE_W-1:0]         i_to_node,
    input  logic [rtsp_pkg::WEIGHT_BITS-1:0]    i_edge_weight,
    input  logic                                i_cfg_we,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_done,
    output logic [rtsp_pkg::DIST_BITS-1:0]      o_forward_distance,
    output logic [rtsp_pkg::DIST_BITS-1:0]      o_backward_distance,
    output logic [rtsp_pkg::TOTAL_W-1:0]        o_total_distance,
    output logic                                o_unreachable
);
    import rtsp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rtsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    rtsp_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_from_node         (i_from_node),
        .i_to_node           (i_to_node),
        .i_edge_weight       (i_edge_weight),
        .o_forward_distance  (o_forward_distance),
        .o_backward_distance (o_backward_distance),
        .o_total_distance    (o_total_distance),
        .o_unreachable       (o_unreachable)
    );

endmodule

### rtl/rtsp_checker.sv
module rtsp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic                                i_func,
    input logic                                o_done,
    input logic [rtsp_pkg::DIST_BITS-1:0]      o_forward_distance,
    input logic [rtsp_pkg::DIST_BITS-1:0]      o_backward_distance,
    input logic [rtsp_pkg::TOTAL_W-1:0]        o_total_distance,
    input logic                                o_unreachable
);
    import rtsp_pkg::*;

    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("not busy after reset");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_func) |=> o_busy)
        else $error("run transaction did not start");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result while idle");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_unreachable) |->
        (o_total_distance == ({1'b0, o_forward_distance} + {1'b0, o_backward_distance})))
        else $error("total is not the sum of both legs");

endmodule

bind round_trip_shortest_path_top rtsp_checker u_rtsp_checker (.*);

### tb/round_trip_shortest_path_top_tb.sv
`timescale 1ns / 1ps

module round_trip_shortest_path_top_tb;
    import rtsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000000;
    localparam bit FUNC_WRITE = 1'b0;
    localparam bit FUNC_RUN   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [DIST_BITS-1:0] fwd;
        logic [DIST_BITS-1:0] bwd;
        logic [TOTAL_W-1:0]   total;
        logic                 unreach;
    } t_trip;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic                   i_func;
    logic [NODE_W-1:0]      i_from_node;
    logic [NODE_W-1:0]      i_to_node;
    logic [WEIGHT_BITS-1:0] i_edge_weight;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_done;
    logic [DIST_BITS-1:0]   o_forward_distance;
    logic [DIST_BITS-1:0]   o_backward_distance;
    logic [TOTAL_W-1:0]     o_total_distance;
    logic                   o_unreachable;

    round_trip_shortest_path_top dut (.*);

    logic [WEIGHT_BITS-1:0] weight_mem [MAX_NODES*MAX_NODES];
    logic [DIST_BITS-1:0]   dist_tab [MAX_NODES];
    bit                     seen_tab [MAX_NODES];
    logic [DIST_BITS-1:0]   last_fwd;
    int unsigned            nodes_cfg, src_cfg, dst_cfg;
    t_trip                  trip_q [$];
    int                     errors;
    int                     idle_cycles;
    int                     gap_pct;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DIST_BITS-1:0] shortest_leg(int unsigned s, int unsigned t,
                                                          int unsigned n);
        logic [DIST_BITS-1:0] best, du;
        logic [DIST_BITS:0]   cand;
        int unsigned          pick;
        for (int v = 0; v < n; v++) begin
            dist_tab[v] = DIST_INF;
            seen_tab[v] = 0;
        end
        dist_tab[s] = 0;
        for (int r = 0; r + 1 < n; r++) begin
            best = DIST_INF;
            pick = 0;
            for (int v = 0; v < n; v++)
                if (!seen_tab[v] && dist_tab[v] <= best) begin
                    best = dist_tab[v];
                    pick = v;
                end
            seen_tab[pick] = 1;
            du = dist_tab[pick];
            if (du == DIST_INF) continue;
            for (int v = 0; v < n; v++) begin
                logic [WEIGHT_BITS-1:0] w;
                w = weight_mem[pick*MAX_NODES+v];
                if (seen_tab[v] || w == 0) continue;
                cand = du + w;
                if (cand > DIST_MAX) cand = DIST_MAX;
                if (cand[DIST_BITS-1:0] < dist_tab[v]) dist_tab[v] = cand[DIST_BITS-1:0];
            end
        end
        return dist_tab[t];
    endfunction

    function automatic void predict_trip(bit func, int unsigned from, int unsigned to,
                                         logic [WEIGHT_BITS-1:0] w);
        t_trip       tr;
        int unsigned n;
        if (func == FUNC_WRITE) begin
            weight_mem[from*MAX_NODES+to] = w;
            return;
        end
        n = nodes_cfg == 0 ? 1 : (nodes_cfg > MAX_NODES ? MAX_NODES : nodes_cfg);
        if (src_cfg >= n || dst_cfg >= n) begin
            tr.fwd = DIST_INF;
            tr.bwd = DIST_INF;
        end else begin
            last_fwd = shortest_leg(src_cfg, dst_cfg, n);
            tr.fwd = last_fwd;
            tr.bwd = shortest_leg(dst_cfg, src_cfg, n);
        end
        tr.unreach = (tr.fwd == DIST_INF) || (tr.bwd == DIST_INF);
        tr.total = tr.unreach ? {TOTAL_W{1'b1}} : tr.fwd + tr.bwd;
        trip_q.push_back(tr);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_trip ex;
            if (trip_q.size() == 0) begin
                $error("result with no expectation");
                errors++;
            end else begin
                ex = trip_q.pop_front();
                if (o_forward_distance !== ex.fwd) begin
                    $error("forward_distance exp %0d got %0d", ex.fwd, o_forward_distance);
                    errors++;
                end
                if (o_backward_distance !== ex.bwd) begin
                    $error("backward_distance exp %0d got %0d", ex.bwd, o_backward_distance);
                    errors++;
                end
                if (o_total_distance !== ex.total) begin
                    $error("total_distance exp %0d got %0d", ex.total, o_total_distance);
                    errors++;
                end
                if (o_unreachable !== ex.unreach) begin
                    $error("unreachable exp %0d got %0d", ex.unreach, o_unreachable);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(bit func, int unsigned from, int unsigned to, int unsigned w);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start       <= 1;
        i_func        <= func;
        i_from_node   <= NODE_W'(from);
        i_to_node     <= NODE_W'(to);
        i_edge_weight <= WEIGHT_BITS'(w);
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_trip(func, from, to, WEIGHT_BITS'(w));
    endtask

    task automatic wait_drained();
        i_start <= 0;
        @(posedge i_clk);
        while (trip_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        wait_drained();
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_NODE_COUNT:  nodes_cfg = val & 9'h1FF;
            REG_SOURCE_NODE: src_cfg = val & 8'hFF;
            REG_DEST_NODE:   dst_cfg = val & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic set_trip(int unsigned n, int unsigned s, int unsigned d);
        write_reg(REG_NODE_COUNT, n);
        write_reg(REG_SOURCE_NODE, s);
        write_reg(REG_DEST_NODE, d);
    endtask

    task automatic test_directed();
        send_item(FUNC_RUN, 0, 0, 0);
        set_trip(4, 0, 3);
        send_item(FUNC_RUN, 0, 0, 0);
        send_item(FUNC_WRITE, 0, 1, 1);
        send_item(FUNC_WRITE, 1, 3, 16'hFFFF);
        send_item(FUNC_WRITE, 3, 0, 7);
        send_item(FUNC_WRITE, 2, 3, 0);
        send_item(FUNC_RUN, 0, 0, 0);
        send_item(FUNC_WRITE, 255, 255, 16'hFFFF);
        send_item(FUNC_WRITE, 0, 2, 3);
        send_item(FUNC_WRITE, 2, 3, 3);
        send_item(FUNC_RUN, 0, 0, 0);
        set_trip(4, 3, 3);
        send_item(FUNC_RUN, 0, 0, 0);
        set_trip(4, 0, 200);
        send_item(FUNC_RUN, 0, 0, 0);
        set_trip(0, 0, 0);
        send_item(FUNC_RUN, 0, 0, 0);
        write_reg(REG_SPARE, 5);
        set_trip(511, 0, 255);
        send_item(FUNC_RUN, 0, 0, 0);
        for (int i = 0; i < 3; i++) send_item(FUNC_WRITE, i, i + 1, 16'hFFFF);
        set_trip(256, 255, 0);
        send_item(FUNC_RUN, 0, 0, 0);
    endtask

    task automatic test_random(int items);
        int unsigned n;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(15) == 0) begin
                n = $urandom_range(9) == 0 ? $urandom_range(511) : $urandom_range(8, 1);
                set_trip(n, $urandom_range(n < 2 ? 1 : n), $urandom_range(n < 2 ? 1 : n));
                if ($urandom_range(3) == 0) wait_drained();
            end
            if ($urandom_range(9) == 0)
                send_item(FUNC_RUN, $urandom_range(255), $urandom_range(255),
                          $urandom_range(65535));
            else if ($urandom_range(9) == 0)
                send_item(FUNC_WRITE, $urandom_range(255), $urandom_range(255),
                          $urandom_range(65535));
            else
                send_item(FUNC_WRITE, $urandom_range(7), $urandom_range(7),
                          $urandom_range(3) == 0 ? 0 :
                          ($urandom_range(4) == 0 ? $urandom_range(65535) :
                           $urandom_range(20)));
        end
    endtask

    initial begin
        errors = 0;
        gap_pct = 17;
        i_rst_n = 0; i_start = 0; i_func = 0; i_from_node = 0; i_to_node = 0;
        i_edge_weight = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        nodes_cfg = 1; src_cfg = 0; dst_cfg = 0; last_fwd = 0;
        foreach (weight_mem[k]) weight_mem[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_random(160);
        gap_pct = 66;
        test_random(160);
        gap_pct = 0;
        test_random(160);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && trip_q.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
